// ===== src/udec_pkg.sv =====
package udec_pkg;

   // result queue between front and back
   localparam int UDEC_QUEUE_DEPTH = 2;

   // at most three code units leave for one input byte
   localparam int UDEC_MAX_UNITS = 3;

   // byte class masks and tags
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD3_MASK = 8'hE0;

   // number of held bytes in the front
   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_ONE  = 2'd1,
      PEND_TWO  = 2'd2
   } pend_type;

   // code units caused by one accepted byte
   typedef struct packed {
      logic [UDEC_MAX_UNITS-1:0][15:0] unit;
      logic [1:0]                      count;       // 1 to 3
      logic                            string_end;  // last byte of the string
   } bundle_type;

endpackage

// ===== src/udec_front.sv =====
module udec_front
   import udec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] data_byte,
   input  logic       string_end,
   input  logic       queue_full,
   output logic       push,
   output bundle_type push_bundle
);

   pend_type   pend_count_ff, pend_count_in;
   logic [7:0] pend_first_ff, pend_first_in;
   logic [7:0] pend_second_ff, pend_second_in;
   logic       accept;
   logic       is_cont;
   logic       three;
   logic       do_fresh;
   logic [1:0] n;
   bundle_type bnd;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign is_cont  = (data_byte & CONT_MASK) == CONT_TAG;
   assign three    = (pend_first_ff & LEAD3_MASK) == LEAD3_MASK;

   always_comb begin
      bnd            = '0;
      n              = 2'd0;
      do_fresh       = 1'b0;
      pend_count_in  = pend_count_ff;
      pend_first_in  = pend_first_ff;
      pend_second_in = pend_second_ff;
      case (pend_count_ff)
         PEND_NONE: begin
            do_fresh = 1'b1;
         end
         PEND_ONE: begin
            if (is_cont && three) begin
               pend_second_in = data_byte;
               pend_count_in  = PEND_TWO;
            end else if (is_cont) begin
               bnd.unit[0]   = {5'd0, pend_first_ff[4:0], data_byte[5:0]};
               n             = 2'd1;
               pend_count_in = PEND_NONE;
            end else begin
               bnd.unit[0]   = {8'h00, pend_first_ff};
               n             = 2'd1;
               pend_count_in = PEND_NONE;
               do_fresh      = 1'b1;
            end
         end
         PEND_TWO: begin
            pend_count_in = PEND_NONE;
            if (is_cont) begin
               bnd.unit[0] = {pend_first_ff[3:0], pend_second_ff[5:0], data_byte[5:0]};
               n           = 2'd1;
            end else begin
               bnd.unit[0] = {8'h00, pend_first_ff};
               bnd.unit[1] = {8'h00, pend_second_ff};
               n           = 2'd2;
               do_fresh    = 1'b1;
            end
         end
         default: begin
            pend_count_in = PEND_NONE;
            do_fresh      = 1'b1;
         end
      endcase

      // fresh look at the byte: lead bytes are held, all else passes raw
      if (do_fresh) begin
         if (data_byte[7] && !is_cont) begin
            pend_first_in  = data_byte;
            pend_second_in = 8'h00;
            pend_count_in  = PEND_ONE;
         end else if (n != 2'd3) begin
            bnd.unit[n] = {8'h00, data_byte};
            n           = n + 2'd1;
         end
      end

      // end of string: held bytes go out raw, oldest first
      if (string_end) begin
         if (pend_count_in != PEND_NONE && n != 2'd3) begin
            bnd.unit[n] = {8'h00, pend_first_in};
            n           = n + 2'd1;
         end
         if (pend_count_in == PEND_TWO && n != 2'd3) begin
            bnd.unit[n] = {8'h00, pend_second_in};
            n           = n + 2'd1;
         end
         pend_count_in  = PEND_NONE;
         pend_first_in  = 8'h00;
         pend_second_in = 8'h00;
      end

      bnd.count      = n;
      bnd.string_end = string_end;
   end

   assign push        = accept && (n != 2'd0);
   assign push_bundle = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_count_ff  <= PEND_NONE;
         pend_first_ff  <= 8'h00;
         pend_second_ff <= 8'h00;
      end else if (accept) begin
         pend_count_ff  <= pend_count_in;
         pend_first_ff  <= pend_first_in;
         pend_second_ff <= pend_second_in;
      end
   end

   // the last byte of a string always produces at least one unit
   a_end_pushes: assert property (@(posedge clock) disable iff (reset)
      (accept && string_end) |-> push)
      else $error("end of string produced no code unit");

endmodule

// ===== src/udec_queue.sv =====
module udec_queue
   import udec_pkg::*;
#(
   parameter int Depth = UDEC_QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_bundle,
   input  logic       pop,
   output logic       full,
   output logic       head_valid,
   output bundle_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   bundle_type            entry_ff [Depth];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  do_pop;

   assign full       = count_ff == CntW'(Depth);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

endmodule

// ===== src/udec_back.sv =====
module udec_back
   import udec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  bundle_type  head,
   output logic        pop,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [15:0] code_unit,
   output logic        run_last,
   output logic        string_last
);

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [15:0] unit_ff;
   logic        run_last_ff;
   logic        string_last_ff;
   logic        load;
   logic        is_last;

   assign load    = head_valid && (!valid_ff || out_ready);
   assign is_last = idx_ff == (head.count - 2'd1);
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         unit_ff        <= head.unit[idx_ff];
         run_last_ff    <= is_last;
         string_last_ff <= is_last && head.string_end;
      end
   end

   assign out_valid   = valid_ff;
   assign code_unit   = unit_ff;
   assign run_last    = run_last_ff;
   assign string_last = string_last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff < head.count))
      else $error("unit index past bundle count");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == 2'd0))
      else $error("unit index left over with empty queue");

   a_string_last_run: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && string_last_ff) |-> run_last_ff)
      else $error("end of string not on last unit of its byte");

endmodule

// ===== src/utf8_to_ucs2_stream_decoder.sv =====
// channel   dir  tdata                  tlast        tuser
// req_      in   [7:0] data_byte        string_end   -
// rsp_      out  [15:0] code_unit       run_last     [0] string_last
//
// one byte per cycle in while the result queue has room; one code unit per cycle out while rsp_tready is high
// a byte that causes k units (k is 0 to 3) comes out as k code units, one after another
// the front decides all units of a byte at once and queues them as one bundle
// req_tready drops only while the result queue is full
// reset clears held bytes, empties the queue and drops the output valid
module utf8_to_ucs2_stream_decoder
   import udec_pkg::*;
#(
   parameter int QueueDepth = UDEC_QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   // byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // string_end
   // code unit stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser    // [0] string_last
);

   logic       push;
   bundle_type push_bundle;
   logic       queue_full;
   logic       pop;
   logic       head_valid;
   bundle_type head;

   // front: holds lead bytes and decodes each byte into a bundle of units
   udec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .data_byte   (req_tdata),
      .string_end  (req_tlast),
      .queue_full  (queue_full),
      .push        (push),
      .push_bundle (push_bundle)
   );

   // bundles waiting for the back end
   udec_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .full        (queue_full),
      .head_valid  (head_valid),
      .head        (head)
   );

   // back: walks the units of the head bundle into the output register
   udec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .code_unit   (rsp_tdata),
      .run_last    (rsp_tlast),
      .string_last (rsp_tuser)
   );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import udec_pkg::*;

   // clock period is 4 units, so the watchdog is reckoned in cycles times 4
   localparam int WATCHDOG_CYCLES = 200000;
   localparam int TAIL_CYCLES     = 16;
   localparam int HOLD_CYCLES     = 150;

   // one code unit as the decoder should deliver it
   typedef struct {
      logic [15:0] unit;
      logic        run_last;
      logic        string_last;
   } unit_exp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tlast;    // string_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [15:0] code_unit
   logic        rsp_tlast;    // run_last
   logic        rsp_tuser;    // [0] string_last

   // code units still owed by the decoder, oldest first
   unit_exp_type expected_units[$];
   // units produced by the byte being decoded
   logic [15:0] unit_buf[$];

   // decoder state as the predictor tracks it
   logic [7:0]  held_first;
   logic [7:0]  held_second;
   pend_type    held_count;

   // idle percentages for each side and the long receiver hold
   int          req_idle_pct;
   int          rsp_idle_pct;
   int          rsp_hold_left;
   int          error_count;
   int          bytes_sent;

   utf8_to_ucs2_stream_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // free running clock, 2 high and 2 low
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog against a hung handshake
   initial begin
      #(WATCHDOG_CYCLES * 4);
      $display("tb: failure");
      $finish;
   end

   // ----------------------------------------------------------------------
   // predictor
   // ----------------------------------------------------------------------

   function automatic logic is_cont(input logic [7:0] b);
      return (b & CONT_MASK) == CONT_TAG;
   endfunction

   // byte seen with nothing held: ascii and stray continuations go out raw,
   // any lead is held for the bytes after it
   function automatic void take_fresh(input logic [7:0] b);
      if (!b[7] || is_cont(b)) begin
         unit_buf.push_back({8'h00, b});
      end else begin
         held_first  = b;
         held_second = 8'h00;
         held_count  = PEND_ONE;
      end
   endfunction

   // work out every code unit one accepted byte causes and queue them
   function automatic void predict_units(input logic [7:0] b, input logic str_end);
      unit_exp_type want;
      int           n;
      unit_buf.delete();
      case (held_count)
         PEND_NONE: begin
            take_fresh(b);
         end
         PEND_ONE: begin
            if (is_cont(b) && ((held_first & LEAD3_MASK) == LEAD3_MASK)) begin
               // first continuation of a three-byte form
               held_second = b;
               held_count  = PEND_TWO;
            end else if (is_cont(b)) begin
               unit_buf.push_back({5'd0, held_first[4:0], b[5:0]});
               held_count = PEND_NONE;
            end else begin
               // lead not completed, emit it raw and look at the new byte again
               unit_buf.push_back({8'h00, held_first});
               held_count = PEND_NONE;
               take_fresh(b);
            end
         end
         default: begin
            held_count = PEND_NONE;
            if (is_cont(b)) begin
               unit_buf.push_back({held_first[3:0], held_second[5:0], b[5:0]});
            end else begin
               // broken three-byte form, both held bytes go out raw
               unit_buf.push_back({8'h00, held_first});
               unit_buf.push_back({8'h00, held_second});
               take_fresh(b);
            end
         end
      endcase
      if (str_end) begin
         // flush whatever is still held, oldest first
         if (held_count != PEND_NONE && unit_buf.size() < UDEC_MAX_UNITS)
            unit_buf.push_back({8'h00, held_first});
         if (held_count == PEND_TWO && unit_buf.size() < UDEC_MAX_UNITS)
            unit_buf.push_back({8'h00, held_second});
         held_count  = PEND_NONE;
         held_first  = 8'h00;
         held_second = 8'h00;
      end
      n = unit_buf.size();
      for (int k = 0; k < n; k++) begin
         want.unit        = unit_buf[k];
         want.run_last    = (k == n - 1);
         want.string_last = (k == n - 1) && str_end;
         expected_units.push_back(want);
      end
   endfunction

   // ----------------------------------------------------------------------
   // byte sender
   // ----------------------------------------------------------------------

   // offer one byte, optionally after random idle cycles, and wait for the
   // transaction; tvalid stays high so back to back bytes need no toggle
   task automatic send_byte(input logic [7:0] b, input logic str_end);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= str_end;
      do @(posedge clock); while (!req_tready);
      predict_units(b, str_end);
      bytes_sent++;
   endtask

   function automatic logic [7:0] rand_cont();
      return {2'b10, 6'($urandom)};
   endfunction

   // one string of random characters, mostly well formed utf-8 with some
   // noise, stray continuations and cut-off forms mixed in
   task automatic send_random_string();
      logic [7:0] text[$];
      int         n_chars;
      int         kind;
      n_chars = $urandom_range(1, 8);
      repeat (n_chars) begin
         kind = $urandom_range(0, 11);
         case (kind)
            0, 1, 2: begin
               text.push_back(8'($urandom_range(8'h01, 8'h7F)));
            end
            3, 4: begin
               text.push_back(8'($urandom_range(8'hC0, 8'hDF)));
               text.push_back(rand_cont());
            end
            5, 6, 7: begin
               text.push_back(8'($urandom_range(8'hE0, 8'hFF)));
               text.push_back(rand_cont());
               text.push_back(rand_cont());
            end
            8: begin
               // lead with at most one continuation after it, so its tail may be cut off
               text.push_back(8'($urandom_range(8'hC0, 8'hFF)));
               if ($urandom_range(1)) text.push_back(rand_cont());
            end
            9: begin
               text.push_back(rand_cont());
            end
            default: begin
               text.push_back(8'($urandom_range(8'h01, 8'hFF)));
            end
         endcase
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   // ----------------------------------------------------------------------
   // receiver and checker
   // ----------------------------------------------------------------------

   // rsp_tready, with a long hold counted down here when one is requested
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // every code unit transaction is matched against the oldest expectation
   always @(posedge clock) begin : check_units
      unit_exp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_units.size() == 0) begin
            $error("unexpected code unit %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_units.pop_front();
            if (rsp_tdata !== want.unit) begin
               $error("code_unit expected %h actual %h", want.unit, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.run_last) begin
               $error("run_last expected %b actual %b", want.run_last, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser !== want.string_last) begin
               $error("string_last expected %b actual %b", want.string_last, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // stop offering bytes and wait until every owed unit has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_units.size() != 0) @(posedge clock);
   endtask

   // ----------------------------------------------------------------------
   // tests
   // ----------------------------------------------------------------------

   // extremes of each form and the corner cases, as {string_end, byte}
   task automatic test_directed_cases();
      logic [8:0] seq[$];
      seq = '{
         9'h101, 9'h17F,                      // ascii extremes, one-byte strings
         9'h0C0, 9'h080, 9'h0DF, 9'h0BF,      // two-byte forms, lowest and highest
         9'h0E0, 9'h080, 9'h080,              // three-byte forms
         9'h0EF, 9'h0BF, 9'h0BF,
         9'h0FF, 9'h0BF, 9'h0BF,              // f0..ff lead, low nibble only
         9'h080,                              // stray continuation
         9'h0C3, 9'h041,                      // two-byte lead cut short
         9'h0E2, 9'h082, 9'h041,              // three-byte form broken after two
         9'h0E2, 9'h082, 9'h1C3,              // broken, new lead flushed at end
         9'h1E2                               // lone lead flushed at end
      };
      foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
      wait_drained();
   endtask

   // random strings until about n_bytes have gone in
   task automatic test_random_text(input int n_bytes);
      int stop_at;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) send_random_string();
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering bytes, so the
   // result queue fills and req_tready must fall
   task automatic test_output_hold();
      req_idle_pct  = 0;
      rsp_hold_left = HOLD_CYCLES;
      for (int i = 0; i < 20; i++)
         send_byte(8'($urandom_range(8'h01, 8'h7F)), (i % 5) == 4);
      wait_drained();
   endtask

   // ----------------------------------------------------------------------
   // main sequence
   // ----------------------------------------------------------------------

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      held_first    = 8'h00;
      held_second   = 8'h00;
      held_count    = PEND_NONE;
      req_idle_pct  = 19;
      rsp_idle_pct  = 54;
      rsp_hold_left = 0;
      error_count   = 0;
      bytes_sent    = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver heavily
      test_directed_cases();
      test_random_text(90);

      // the other way round
      req_idle_pct = 54;
      rsp_idle_pct = 19;
      test_random_text(90);

      // no idling on either side
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_text(90);

      test_output_hold();

      // let the pipeline settle to catch stray units
      rsp_idle_pct = 0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
